// ===== rtl/core/column_histogram_percentile_snr_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Column histogram percentile SNR unit: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COLUMN_HISTOGRAM_PERCENTILE_SNR_UNIT_ASSERT_SVH
`define COLUMN_HISTOGRAM_PERCENTILE_SNR_UNIT_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define CHPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define CHPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/chps_pkg.sv =====
// ----------------------------------------------------------------------------
// chps_pkg
// Types and fixed constants of the column histogram percentile SNR unit.
// ----------------------------------------------------------------------------
package chps_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 13;
    localparam int CUM_W      = CNT_W + 1;
    localparam int CFG_BC_W   = 9;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int BIN_OUT_W  = 8;
    localparam int SNR_W      = 14;
    localparam int LOG_W      = 32;
    localparam int FRAC_BITS  = 28;
    localparam int SCALE_W    = 26;
    localparam int PROD_W     = LOG_W + SCALE_W;
    localparam int RND_SHIFT  = 44;

    localparam logic [CNT_W-1:0]   COUNT_MAX     = 13'd8191;
    localparam logic [SCALE_W-1:0] SNR_SCALE_Q16 = 26'd39456604;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_UNIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG_THRESH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_THRESH = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_UP_RD,
        ST_UP_EV,
        ST_DN_RD,
        ST_DN_EV,
        ST_LOGS_GO,
        ST_LOGS_WAIT,
        ST_LOGB_GO,
        ST_LOGB_WAIT,
        ST_MUL,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/column_histogram_percentile_snr_unit.sv =====
// Sample items are accepted only in idle: each one takes the accepting cycle, the divider,
// then a read and a write-back of one histogram entry before the next is accepted.
// A column's last item adds an upward and a downward walk (read, then compare, per bin),
// two shared 28-step logarithms and a clearing pass over all BINS entries.
// After reset all BINS entries of the histogram memory are cleared before any item.
// ----------------------------------------------------------------------------
// column_histogram_percentile_snr_unit
// Per-column histogram in a single-port memory, percentile walks and SNR.
// ----------------------------------------------------------------------------
module column_histogram_percentile_snr_unit #(
    parameter int BINS = 256
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [chps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [chps_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [chps_pkg::SAMPLE_W-1:0]        sample,
    input  logic                                 last_in_column,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [chps_pkg::BIN_OUT_W-1:0]       background_bin,
    output logic [chps_pkg::BIN_OUT_W-1:0]       signal_bin,
    output logic signed [chps_pkg::SNR_W-1:0]    snr_centi_db
);
    import chps_pkg::*;

    `include "column_histogram_percentile_snr_unit_assert.svh"

    localparam int IDX_W = $clog2(BINS);
    localparam int BC_W  = $clog2(BINS + 1);
    localparam int BCX_W = (BC_W > CFG_BC_W) ? BC_W : CFG_BC_W;

    state_t state_reg, state_next;

    logic [CFG_BC_W-1:0] bin_count_reg;
    logic [SAMPLE_W-1:0] bin_unit_reg;
    logic [CNT_W-1:0]    bg_thr_reg;
    logic [CNT_W-1:0]    sig_thr_reg;

    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [CUM_W-1:0]    cum_reg, cum_next;
    logic [IDX_W-1:0]    bg_reg, bg_next;
    logic [IDX_W-1:0]    sg_reg, sg_next;
    logic                last_reg, last_next;
    logic [LOG_W-1:0]    ls_reg, ls_next;
    logic [LOG_W-1:0]    lb_reg, lb_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                neg_reg, neg_next;

    logic                out_valid_reg, out_valid_next;
    logic [BIN_OUT_W-1:0] bg_out_reg, bg_out_next;
    logic [BIN_OUT_W-1:0] sg_out_reg, sg_out_next;
    logic [SNR_W-1:0]    snr_reg, snr_next;

    logic [CNT_W-1:0]    mem [BINS];
    logic [CNT_W-1:0]    rd_data_reg;
    logic                mem_we;
    logic [CNT_W-1:0]    mem_wdata;

    logic                div_start, div_done;
    logic [SAMPLE_W-1:0] div_q;
    logic                log_start, log_done;
    logic [IDX_W-1:0]    log_k;
    logic [LOG_W-1:0]    log_q;

    logic [BCX_W-1:0]    bc_raw, bc_eff;
    logic [IDX_W-1:0]    last_bin;
    logic [IDX_W-1:0]    clamp_idx;
    logic [CUM_W:0]      cum_sum;
    logic [CUM_W-1:0]    cum_sat;
    logic [IDX_W-1:0]    s_eff, b_eff;
    logic [LOG_W-1:0]    mag;
    logic [PROD_W-1:0]   rnd;
    logic [SNR_W-1:0]    r_mag;
    logic [IDX_W+7:0]    bg_wide, sg_wide;

    chps_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sample),
        .divisor  (bin_unit_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    chps_log2 #(.K_W(IDX_W)) u_log2
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .k     (log_k),
        .done  (log_done),
        .log_q (log_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= 9'd256;
            bin_unit_reg  <= 16'd1;
            bg_thr_reg    <= '0;
            sig_thr_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIN_COUNT:  bin_count_reg <= cfg_wdata[CFG_BC_W-1:0];
                REG_BIN_UNIT:   bin_unit_reg  <= cfg_wdata[SAMPLE_W-1:0];
                REG_BG_THRESH:  bg_thr_reg    <= cfg_wdata[CNT_W-1:0];
                REG_SIG_THRESH: sig_thr_reg   <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Histogram store: one write and one registered read a cycle at ptr_reg.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    always_comb
    begin
        bc_raw = BCX_W'(bin_count_reg);
        if (bc_raw == '0)
        begin
            bc_eff = BCX_W'(1);
        end
        else if (bc_raw > BCX_W'(BINS))
        begin
            bc_eff = BCX_W'(BINS);
        end
        else
        begin
            bc_eff = bc_raw;
        end
        last_bin  = IDX_W'(bc_eff - BCX_W'(1));
        clamp_idx = (div_q >= SAMPLE_W'(bc_eff)) ? last_bin : IDX_W'(div_q);
        cum_sum   = {1'b0, cum_reg} + (CUM_W + 1)'(rd_data_reg);
        cum_sat   = cum_sum[CUM_W] ? {CUM_W{1'b1}} : cum_sum[CUM_W-1:0];
        s_eff     = (sg_reg == '0) ? IDX_W'(1) : sg_reg;
        b_eff     = (bg_reg == '0) ? IDX_W'(1) : bg_reg;
        log_k     = (state_reg == ST_LOGS_GO) ? s_eff : b_eff;
        mag       = (ls_reg < lb_reg) ? (lb_reg - ls_reg) : (ls_reg - lb_reg);
        rnd       = prod_reg + (PROD_W'(1) << (RND_SHIFT - 1));
        r_mag     = rnd[RND_SHIFT +: SNR_W];
        bg_wide   = (IDX_W + 8)'(bg_reg);
        sg_wide   = (IDX_W + 8)'(sg_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cum_next       = cum_reg;
        bg_next        = bg_reg;
        sg_next        = sg_reg;
        last_next      = last_reg;
        ls_next        = ls_reg;
        lb_next        = lb_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        bg_out_next    = bg_out_reg;
        sg_out_next    = sg_out_reg;
        snr_next       = snr_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        div_start      = 1'b0;
        log_start      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (ptr_reg == IDX_W'(BINS - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_start  = 1'b1;
                    last_next  = last_in_column;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ptr_next   = clamp_idx;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;
                if (last_reg)
                begin
                    ptr_next   = '0;
                    cum_next   = '0;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UP_RD:
            begin
                state_next = ST_UP_EV;
            end
            ST_UP_EV:
            begin
                cum_next = cum_sat;
                if (cum_sat >= {1'b0, bg_thr_reg} || ptr_reg == last_bin)
                begin
                    // Threshold never reached leaves the background bin at zero.
                    bg_next    = (cum_sat >= {1'b0, bg_thr_reg}) ? ptr_reg : '0;
                    ptr_next   = last_bin;
                    cum_next   = '0;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_UP_RD;
                end
            end
            ST_DN_RD:
            begin
                state_next = ST_DN_EV;
            end
            ST_DN_EV:
            begin
                cum_next = cum_sat;
                if (cum_sat >= {1'b0, sig_thr_reg} || ptr_reg == '0)
                begin
                    sg_next    = (cum_sat >= {1'b0, sig_thr_reg}) ? ptr_reg : '0;
                    state_next = ST_LOGS_GO;
                end
                else
                begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_DN_RD;
                end
            end
            ST_LOGS_GO:
            begin
                log_start  = 1'b1;
                state_next = ST_LOGS_WAIT;
            end
            ST_LOGS_WAIT:
            begin
                if (log_done)
                begin
                    ls_next    = log_q;
                    state_next = ST_LOGB_GO;
                end
            end
            ST_LOGB_GO:
            begin
                log_start  = 1'b1;
                state_next = ST_LOGB_WAIT;
            end
            ST_LOGB_WAIT:
            begin
                if (log_done)
                begin
                    lb_next    = log_q;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                neg_next   = (ls_reg < lb_reg);
                prod_next  = PROD_W'(mag) * PROD_W'(SNR_SCALE_Q16);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    bg_out_next    = bg_wide[BIN_OUT_W-1:0];
                    sg_out_next    = sg_wide[BIN_OUT_W-1:0];
                    snr_next       = neg_reg ? (SNR_W'(0) - r_mag) : r_mag;
                    ptr_next       = '0;
                    state_next     = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cum_reg    <= cum_next;
        bg_reg     <= bg_next;
        sg_reg     <= sg_next;
        ls_reg     <= ls_next;
        lb_reg     <= lb_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        bg_out_reg <= bg_out_next;
        sg_out_reg <= sg_out_next;
        snr_reg    <= snr_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign background_bin = bg_out_reg;
    assign signal_bin     = sg_out_reg;
    assign snr_centi_db   = signed'(snr_reg);

    `CHPS_ASSERT_SAME(a_update_in_range, state_reg == ST_RD, ptr_reg <= last_bin,
        "histogram update address beyond bins in use")
    `CHPS_ASSERT_SAME(a_walk_in_range, state_reg == ST_UP_EV || state_reg == ST_DN_EV,
        ptr_reg <= last_bin, "walk address beyond bins in use")
    `CHPS_ASSERT_NEXT(a_clear_ends, state_reg == ST_CLEAR && ptr_reg == IDX_W'(BINS - 1),
        state_reg == ST_IDLE && ptr_reg == '0, "clearing pass did not end in idle")

endmodule

// ===== rtl/core/chps_div.sv =====
// ----------------------------------------------------------------------------
// chps_div
// Restoring divider, one quotient bit per cycle. A zero divisor acts as one.
// ----------------------------------------------------------------------------
module chps_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [chps_pkg::SAMPLE_W-1:0] dividend,
    input  logic [chps_pkg::SAMPLE_W-1:0] divisor,
    output logic                          done,
    output logic [chps_pkg::SAMPLE_W-1:0] quotient
);
    import chps_pkg::*;

    localparam int CNT_BITS = $clog2(SAMPLE_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] quo_reg, quo_next;
    logic [SAMPLE_W-1:0] div_reg, div_next;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   diff;
    logic                fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SAMPLE_W-1]};
        diff      = trial - {1'b0, div_reg};
        fits      = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(SAMPLE_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = (divisor == '0) ? SAMPLE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            quo_next = {quo_reg[SAMPLE_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/chps_log2.sv =====
// ----------------------------------------------------------------------------
// chps_log2
// Base-two logarithm in Q4.28 by repeated squaring, one fraction bit a cycle.
// ----------------------------------------------------------------------------
module chps_log2 #(
    parameter int K_W = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [K_W-1:0]             k,
    output logic                       done,
    output logic [chps_pkg::LOG_W-1:0] log_q
);
    import chps_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [LOG_W-1:0] x_reg, x_next;
    logic [LOG_W-1:0] res_reg, res_next;
    logic [4:0]       top;
    logic [63:0]      prod;
    logic [33:0]      sq;
    logic             hi;

    always_comb
    begin
        top = '0;
        for (int i = 0; i < K_W; i++)
        begin
            if (k[i])
            begin
                top = 5'(i);
            end
        end
        prod      = 64'(x_reg) * 64'(x_reg);
        sq        = prod[63:30];
        // The square of a mantissa in [1,2) reaching 2 sets the next bit.
        hi        = (sq[33:31] != 3'b000);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(FRAC_BITS - 1);
            x_next    = LOG_W'(k) << (5'd30 - top);
            res_next  = LOG_W'(top) << FRAC_BITS;
        end
        else if (busy_reg)
        begin
            x_next   = hi ? sq[32:1] : sq[31:0];
            res_next = res_reg | (LOG_W'(hi) << cnt_reg);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
    end

    assign done  = done_reg;
    assign log_q = res_reg;

endmodule
